### design/eau_pkg.sv
// ----------------------------------------------------------------------------
// Effective address unit package
// Operation codes, address source selects and controller/datapath structs.
// ----------------------------------------------------------------------------
package eau_pkg;

    typedef enum logic [3:0] {
        OP_ZP_RD   = 4'd0,
        OP_ZP_WR   = 4'd1,
        OP_ABS_RD  = 4'd2,
        OP_ABS_WR  = 4'd3,
        OP_WORD_RD = 4'd4,
        OP_IX_RD   = 4'd5,
        OP_IX_WR   = 4'd6,
        OP_IY_RD   = 4'd7,
        OP_IY_WR   = 4'd8,
        OP_JMP_IND = 4'd9
    } t_op;

    // Address sources for the memory port.
    typedef enum logic [2:0] {
        ASEL_ADDR,
        ASEL_ADDR1,
        ASEL_ZP,
        ASEL_ZP1,
        ASEL_PTR,
        ASEL_PTR1,
        ASEL_EA
    } t_asel;

    typedef struct packed {
        logic  load;
        logic  mem_en;
        logic  mem_we;
        t_asel asel;
        logic  ld_zp;
        logic  ld_lo;
        logic  ld_ptr;
        logic  ld_ea;
        logic  ld_res;
    } t_dp_cmd;

    typedef struct packed {
        t_op op;
    } t_dp_status;

    function automatic logic is_write(input t_op op);
        is_write = (op == OP_ZP_WR) || (op == OP_ABS_WR) ||
                   (op == OP_IX_WR) || (op == OP_IY_WR);
    endfunction

endpackage

### design/eau_if.sv
// ----------------------------------------------------------------------------
// Effective address unit channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface eau_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [15:0] address;
    logic [7:0]  index_value;
    logic [7:0]  write_data;

    modport source (output valid, operation, address, index_value, write_data,
                    input ready);
    modport sink (input valid, operation, address, index_value, write_data,
                  output ready);
endinterface

interface eau_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [15:0] effective_address;

    modport source (output valid, read_data, effective_address, input ready);
    modport sink (input valid, read_data, effective_address, output ready);
endinterface

### design/eau_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module eau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/eau_ctrl.sv
// ----------------------------------------------------------------------------
// Effective address unit controller
// Steps each request through its pointer fetches, access and result hand-off.
// ----------------------------------------------------------------------------
module eau_ctrl import eau_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [3:0] i_in_op,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_JMP_HI,
        S_JMP_PTR,
        S_WORD_LO,
        S_WORD_HI,
        S_ZP_LO,
        S_ZP_HI,
        S_PTR_CAP,
        S_ACCESS,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd         = '0;
        cmd.asel    = ASEL_ADDR;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    case (t_op'(i_in_op))
                        OP_ZP_RD, OP_ZP_WR, OP_ABS_RD, OP_ABS_WR: n_state = S_ACCESS;
                        OP_WORD_RD: n_state = S_WORD_LO;
                        OP_IX_RD, OP_IX_WR, OP_IY_RD, OP_IY_WR, OP_JMP_IND: begin
                            n_state = S_FETCH;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_FETCH: begin
                cmd.mem_en = 1'b1;
                cmd.asel   = ASEL_ADDR;
                n_state    = (i_status.op == OP_JMP_IND) ? S_JMP_HI : S_ZP_LO;
            end
            S_JMP_HI: begin
                cmd.ld_lo  = 1'b1;
                cmd.mem_en = 1'b1;
                cmd.asel   = ASEL_ADDR1;
                n_state    = S_JMP_PTR;
            end
            S_JMP_PTR: begin
                cmd.ld_ptr = 1'b1;
                n_state    = S_WORD_LO;
            end
            S_WORD_LO: begin
                cmd.mem_en = 1'b1;
                cmd.asel   = ASEL_PTR;
                n_state    = S_WORD_HI;
            end
            S_WORD_HI: begin
                cmd.ld_lo  = 1'b1;
                cmd.mem_en = 1'b1;
                cmd.asel   = ASEL_PTR1;
                n_state    = S_FINISH;
            end
            S_ZP_LO: begin
                cmd.ld_zp  = 1'b1;
                cmd.mem_en = 1'b1;
                cmd.asel   = ASEL_ZP;
                n_state    = S_ZP_HI;
            end
            S_ZP_HI: begin
                cmd.ld_lo  = 1'b1;
                cmd.mem_en = 1'b1;
                cmd.asel   = ASEL_ZP1;
                n_state    = S_PTR_CAP;
            end
            S_PTR_CAP: begin
                cmd.ld_ea = 1'b1;
                n_state   = S_ACCESS;
            end
            S_ACCESS: begin
                cmd.mem_en = 1'b1;
                cmd.mem_we = is_write(i_status.op);
                cmd.asel   = ASEL_EA;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                // The read data register holds while no access is issued,
                // so the result may wait here for the output slot.
                if (!r_out_valid || i_out_ready) begin
                    cmd.ld_res  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

### design/eau_dpath.sv
// ----------------------------------------------------------------------------
// Effective address unit datapath
// Request registers, pointer assembly, address select, memory and result.
// ----------------------------------------------------------------------------
module eau_dpath import eau_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  t_dp_cmd     i_cmd,
    input  logic [3:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_index_value,
    input  logic [7:0]  i_write_data,
    output t_dp_status  o_status,
    output logic [15:0] o_read_data,
    output logic [15:0] o_effective_address
);

    t_op         r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_idx;
    logic [7:0]  r_wd;
    logic [7:0]  r_zp;
    logic [7:0]  r_lo;
    logic [15:0] r_ptr;
    logic [15:0] r_ea;
    logic [15:0] r_res_data;
    logic [15:0] r_res_ea;

    logic [7:0]  rdata;
    logic [7:0]  zp_sum;
    logic [15:0] mem_addr;
    logic [15:0] ea_masked;
    logic [15:0] word;
    logic        op_ix;
    logic        op_iy;

    assign op_ix     = (r_op == OP_IX_RD) || (r_op == OP_IX_WR);
    assign op_iy     = (r_op == OP_IY_RD) || (r_op == OP_IY_WR);
    // (zp,X) adds X to the fetched operand byte, wrapping in the zero page.
    assign zp_sum    = rdata + (op_ix ? r_idx : 8'h00);
    assign ea_masked = 16'(r_ea[ADDR_BITS-1:0]);
    assign word      = {rdata, r_lo};

    always_comb begin
        case (i_cmd.asel)
            ASEL_ADDR:  mem_addr = r_addr;
            ASEL_ADDR1: mem_addr = r_addr + 16'd1;
            ASEL_ZP:    mem_addr = {8'h00, zp_sum};
            ASEL_ZP1:   mem_addr = {8'h00, r_zp + 8'd1};
            ASEL_PTR:   mem_addr = r_ptr;
            ASEL_PTR1: begin
                // The indirect jump never carries into the pointer's high byte.
                if (r_op == OP_JMP_IND) begin
                    mem_addr = {r_ptr[15:8], r_ptr[7:0] + 8'd1};
                end else begin
                    mem_addr = r_ptr + 16'd1;
                end
            end
            ASEL_EA:    mem_addr = r_ea;
            default:    mem_addr = r_ea;
        endcase
    end

    eau_ram #(
        .WIDTH (8),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mem_en),
        .i_we    (i_cmd.mem_we),
        .i_addr  (mem_addr[ADDR_BITS-1:0]),
        .i_wdata (r_wd),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_operation);
            r_addr <= i_address;
            r_idx  <= i_index_value;
            r_wd   <= i_write_data;
            r_ptr  <= i_address;
            if ((t_op'(i_operation) == OP_ZP_RD) || (t_op'(i_operation) == OP_ZP_WR)) begin
                r_ea <= {8'h00, i_address[7:0]};
            end else begin
                r_ea <= i_address;
            end
        end
        if (i_cmd.ld_zp) begin
            r_zp <= zp_sum;
        end
        if (i_cmd.ld_lo) begin
            r_lo <= rdata;
        end
        if (i_cmd.ld_ptr) begin
            r_ptr <= word;
        end
        if (i_cmd.ld_ea) begin
            // (zp),Y adds Y to the full 16-bit pointer.
            r_ea <= word + {8'h00, (op_iy ? r_idx : 8'h00)};
        end
        if (i_cmd.ld_res) begin
            case (r_op)
                OP_ZP_RD, OP_ABS_RD, OP_IX_RD, OP_IY_RD: begin
                    r_res_data <= {8'h00, rdata};
                    r_res_ea   <= ea_masked;
                end
                OP_ZP_WR, OP_ABS_WR, OP_IX_WR, OP_IY_WR: begin
                    r_res_data <= 16'h0000;
                    r_res_ea   <= ea_masked;
                end
                OP_WORD_RD: begin
                    r_res_data <= word;
                    r_res_ea   <= ea_masked;
                end
                OP_JMP_IND: begin
                    r_res_data <= word;
                    r_res_ea   <= word;
                end
                default: begin
                    r_res_data <= 16'h0000;
                    r_res_ea   <= 16'h0000;
                end
            endcase
        end
    end

    assign o_status.op         = r_op;
    assign o_read_data         = r_res_data;
    assign o_effective_address = r_res_ea;

endmodule

### design/cpu6502_effective_address_unit_core.sv
// ----------------------------------------------------------------------------
// 6502 effective address unit
// Zero-page, absolute, word, (zp,X), (zp),Y and indirect jump accesses over
// a byte memory, returning the data and the effective address.
// ----------------------------------------------------------------------------
//   channel  | dir | word contents
//   ---------+-----+--------------------------------------------------------
//   i_in     | in  | operation, address, index_value, write_data
//   o_out    | out | read_data, effective_address
//
// A request steps through dependent reads on the single memory port:
// zero-page and absolute accesses go straight to the access, a word read reads
// two bytes, (zp,X) and (zp),Y read the pointer before the access and the
// indirect jump reads the pointer, then the word; unused codes go to the result.
// i_in is taken only while no request is in progress; one result register
// lets the next request be taken while a result waits on o_out.
// Reset clears control only; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module cpu6502_effective_address_unit_core import eau_pkg::*; #(
    parameter int ADDR_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eau_req_if.sink   i_in,
    eau_res_if.source o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    eau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    eau_dpath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_cmd               (cmd),
        .i_operation         (i_in.operation),
        .i_address           (i_in.address),
        .i_index_value       (i_in.index_value),
        .i_write_data        (i_in.write_data),
        .o_status            (status),
        .o_read_data         (o_out.read_data),
        .o_effective_address (o_out.effective_address)
    );

endmodule

### design/eau_checker.sv
// ----------------------------------------------------------------------------
// Effective address unit checker
// Port-level checks on handshake behavior, bound to the top level.
// ----------------------------------------------------------------------------
module eau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_read_data,
    input logic [15:0] i_out_effective_address
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_read_data) &&
                                        $stable(i_out_effective_address))
        else $error("result word changed while stalled");

    // After acceptance the unit is always busy before it can take another request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted back to back");

    // A new result appears only as the unit returns to idle.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result raised while unit still busy");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && !i_in_valid |=> i_in_ready)
        else $error("unit left idle without a request");

endmodule

bind cpu6502_effective_address_unit_core eau_checker u_eau_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .i_in_valid              (i_in.valid),
    .i_in_ready              (i_in.ready),
    .i_out_valid             (o_out.valid),
    .i_out_ready             (o_out.ready),
    .i_out_read_data         (o_out.read_data),
    .i_out_effective_address (o_out.effective_address)
);
